// File: sv/sad_stereo_block_match_unit_defines.svh
// Assertion macros for the SAD stereo block matcher.
`ifndef SAD_STEREO_BLOCK_MATCH_UNIT_DEFINES_SVH
`define SAD_STEREO_BLOCK_MATCH_UNIT_DEFINES_SVH

// Check an implication within the same cycle.
`define SSBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the following cycle.
`define SSBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ssbm_pkg.sv
// Shared constants, types and helpers for the SAD stereo block matcher.
package ssbm_pkg;

    localparam int WINDOW     = 5;
    localparam int WIN        = (WINDOW - 1) / 2;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIX_W      = 8;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int DISP_W     = 8;
    localparam int COST_W     = 16;
    localparam int K_W        = 9;
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int DEPTH      = WINDOW * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [COST_W-1:0] COST_LIMIT = 16'd65532;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_DISP_MIN = 2'd2,
        CFG_DISP_MAX = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RIGHT,
        ST_LEFT,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              is_left;
        logic [SLOT_W-1:0] a;
        logic [SLOT_W-1:0] b;
        logic [SLOT_W-1:0] kb;
        logic [K_W-1:0]    k;
    } rd_tag_t;

    function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W:0] v);
        logic [SLOT_W:0] t;
        t = (v >= (SLOT_W+1)'(WINDOW)) ? v - (SLOT_W+1)'(WINDOW) : v;
        return t[SLOT_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction

endpackage

// File: sv/sad_stereo_block_match_unit.sv
// SAD stereo block matcher top level: line stores, read sequencer and result register.
// Takes left/right grey pixel pairs in raster order and returns, for each valid
// position, the disparity in disp_min..disp_max whose WINDOW x WINDOW patch sum of
// absolute differences is smallest (lower disparity on a tie). A pixel that completes
// no result does not stall the input; one that completes a result stalls it until
// that result is loaded into the output register. The single read port of the line
// stores delivers one pixel per cycle: the right patch first, then the left image
// column by column. With an empty search range (disp_max below disp_min) the left
// pass is skipped. A finished result waits in the output register while the next
// pixel is taken; a second finished result stalls until the first one is transferred.
`include "sad_stereo_block_match_unit_defines.svh"

module sad_stereo_block_match_unit import ssbm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // left_pixel[7:0], right_pixel[15:8]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // out_row[11:0], out_col[21:12], disparity[29:22]
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [DISP_W-1:0]   dmin_reg;
    logic [DISP_W-1:0]   dmax_reg;

    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [SLOT_W-1:0]   rslot_reg, rslot_next;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   ia_reg, ib_reg, kb_reg;
    logic [K_W-1:0]      ik_reg;
    rd_tag_t             tag_reg, tag_next;

    logic [SLOT_W-1:0]   job_slot_reg;
    logic [COL_W-1:0]    rbase_reg, lbase_reg;
    logic [K_W-1:0]      k_last_reg;
    logic                empty_reg;
    logic [ROW_W-1:0]    job_row_reg;
    logic                job_last_reg;

    logic                m_valid_reg;
    logic [ROW_W-1:0]    m_row_reg;
    logic [COL_W-1:0]    m_col_reg;
    logic [DISP_W-1:0]   m_disp_reg;
    logic                m_last_reg;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                col_wrap, row_wrap, accept, emit, out_load, ia_last;
    logic [HEIGHT_W-1:0] r1, rn;
    logic [SLOT_W-1:0]   rs1, rs, rs_adv;
    logic [ROW_W-1:0]    r;
    logic [COL_W-1:0]    c, rbase_new;
    logic [WIDTH_W-1:0]  cn;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [PIX_W-1:0]    left_rd, right_rd;
    logic [DISP_W-1:0]   best_disp;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(640);
            height_reg <= HEIGHT_W'(480);
            dmin_reg   <= '0;
            dmax_reg   <= DISP_W'(64);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WIDTH:    width_reg  <= cfg_wdata[WIDTH_W-1:0];
                CFG_HEIGHT:   height_reg <= cfg_wdata[HEIGHT_W-1:0];
                CFG_DISP_MIN: dmin_reg   <= cfg_wdata[DISP_W-1:0];
                CFG_DISP_MAX: dmax_reg   <= cfg_wdata[DISP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_eff = (width_reg == '0) ? WIDTH_W'(1) :
                   (width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? HEIGHT_W'(1) :
                   (height_reg > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) : height_reg;

    // raster position of the incoming pixel
    always_comb begin
        col_wrap = WIDTH_W'(col_reg) >= w_eff;
        c        = col_wrap ? '0 : col_reg;
        r1       = col_wrap ? HEIGHT_W'(row_reg) + HEIGHT_W'(1) : HEIGHT_W'(row_reg);
        rs1      = col_wrap ? slot_wrap((SLOT_W+1)'(rslot_reg) + (SLOT_W+1)'(1)) : rslot_reg;
        row_wrap = r1 >= h_eff;
        r        = row_wrap ? '0 : r1[ROW_W-1:0];
        rs       = row_wrap ? '0 : rs1;
        emit     = (r >= ROW_W'(2 * WIN)) &&
                   (WIDTH_W'(c) >= WIDTH_W'(2 * WIN) + WIDTH_W'(dmax_reg));
        rbase_new = c - COL_W'(2 * WIN) - COL_W'(dmax_reg);
        cn       = WIDTH_W'(c) + WIDTH_W'(1);
        rn       = HEIGHT_W'(r) + HEIGHT_W'(1);
        rs_adv   = slot_wrap((SLOT_W+1)'(rs) + (SLOT_W+1)'(1));
        if (cn >= w_eff) begin
            col_next = '0;
            if (rn >= h_eff) begin
                row_next   = '0;
                rslot_next = '0;
            end else begin
                row_next   = rn[ROW_W-1:0];
                rslot_next = rs_adv;
            end
        end else begin
            col_next   = cn[COL_W-1:0];
            row_next   = r;
            rslot_next = rs;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign waddr    = store_addr(rs, c);
    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);
    assign ia_last  = (ia_reg == SLOT_W'(WINDOW - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            rslot_reg <= '0;
        end else if (accept) begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            rslot_reg <= rslot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_slot_reg <= rs;
            rbase_reg    <= rbase_new;
            lbase_reg    <= rbase_new + COL_W'(dmin_reg);
            k_last_reg   <= K_W'(dmax_reg) - K_W'(dmin_reg) + K_W'(WINDOW - 1);
            empty_reg    <= dmax_reg < dmin_reg;
            job_row_reg  <= r - ROW_W'(WIN);
            job_last_reg <= (HEIGHT_W'(r) == h_eff - HEIGHT_W'(1)) &&
                            (WIDTH_W'(c) == w_eff - WIDTH_W'(1));
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept && emit) state_next = ST_RIGHT;
            ST_RIGHT:  if (ia_last && ib_reg == SLOT_W'(WINDOW - 1)) begin
                state_next = empty_reg ? ST_DRAIN1 : ST_LEFT;
            end
            ST_LEFT:   if (ia_last && ik_reg == k_last_reg) state_next = ST_DRAIN1;
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_EMIT;
            ST_EMIT:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // read issue
    always_comb begin
        tag_next       = '0;
        tag_next.a     = ia_reg;
        tag_next.b     = ib_reg;
        tag_next.kb    = kb_reg;
        tag_next.k     = ik_reg;
        raddr          = store_addr(slot_wrap((SLOT_W+1)'(job_slot_reg) + (SLOT_W+1)'(1)
                                              + (SLOT_W+1)'(ia_reg)),
                                    rbase_reg + COL_W'(ib_reg));
        case (state_reg)
            ST_RIGHT: tag_next.valid = 1'b1;
            ST_LEFT: begin
                tag_next.valid   = 1'b1;
                tag_next.is_left = 1'b1;
                raddr = store_addr(slot_wrap((SLOT_W+1)'(job_slot_reg) + (SLOT_W+1)'(1)
                                             + (SLOT_W+1)'(ia_reg)),
                                   lbase_reg + COL_W'(ik_reg));
            end
            default: tag_next.valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ia_reg    <= '0;
            ib_reg    <= '0;
            ik_reg    <= '0;
            kb_reg    <= '0;
            tag_reg   <= '0;
        end else begin
            state_reg <= state_next;
            tag_reg   <= tag_next;
            if (accept) begin
                ia_reg <= '0;
                ib_reg <= '0;
                ik_reg <= '0;
                kb_reg <= '0;
            end else if (state_reg == ST_RIGHT || state_reg == ST_LEFT) begin
                if (ia_last) begin
                    ia_reg <= '0;
                    if (state_reg == ST_RIGHT) begin
                        ib_reg <= ib_reg + SLOT_W'(1);
                    end else begin
                        ik_reg <= ik_reg + K_W'(1);
                        kb_reg <= slot_wrap((SLOT_W+1)'(kb_reg) + (SLOT_W+1)'(1));
                    end
                end else begin
                    ia_reg <= ia_reg + SLOT_W'(1);
                end
            end
        end
    end

    ssbm_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_left_store (
        .aclk  (aclk),
        .we    (accept),
        .waddr (waddr),
        .wdata (s_tdata[7:0]),
        .raddr (raddr),
        .rdata (left_rd)
    );

    ssbm_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_right_store (
        .aclk  (aclk),
        .we    (accept),
        .waddr (waddr),
        .wdata (s_tdata[15:8]),
        .raddr (raddr),
        .rdata (right_rd)
    );

    ssbm_sad_acc u_sad_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init      (accept && emit),
        .disp_min  (dmin_reg),
        .tag       (tag_reg),
        .right_pix (right_rd),
        .left_pix  (left_rd),
        .best_disp (best_disp)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_row_reg  <= job_row_reg;
            m_col_reg  <= rbase_reg + COL_W'(WIN);
            m_disp_reg <= best_disp;
            m_last_reg <= job_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_disp_reg, m_col_reg, m_row_reg};
    assign m_tlast  = m_last_reg;

    `SSBM_ASSERT_NOW(a_tag_busy, tag_reg.valid, state_reg != ST_IDLE, "read data while idle")
    `SSBM_ASSERT_NEXT(a_emit_load, out_load, m_tvalid, "result not loaded")
    `SSBM_ASSERT_NOW(a_k_bound, state_reg == ST_LEFT, ik_reg <= k_last_reg, "column overrun")

endmodule

// File: sv/ssbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/ssbm_sad_acc.sv
// Patch cost accumulators and best-disparity tracking for the block matcher.
module ssbm_sad_acc import ssbm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              init,
    input  logic [DISP_W-1:0] disp_min,
    input  rd_tag_t           tag,
    input  logic [PIX_W-1:0]  right_pix,
    input  logic [PIX_W-1:0]  left_pix,
    output logic [DISP_W-1:0] best_disp
);

    logic [PIX_W-1:0]  rpatch_reg [WINDOW][WINDOW];
    logic [COST_W-1:0] acc_reg    [WINDOW];
    logic [COST_W-1:0] acc_sum    [WINDOW];
    logic [SLOT_W-1:0] fin_slot;
    logic              fin_hit;
    logic              fin_valid_reg;
    logic [COST_W-1:0] fin_cost_reg;
    logic [DISP_W-1:0] fin_disp_reg;
    logic [COST_W-1:0] best_cost_reg;
    logic [DISP_W-1:0] best_disp_reg;
    logic [K_W-1:0]    disp_wide;

    always_comb begin
        logic [SLOT_W-1:0] b;
        logic [PIX_W-1:0]  rv;
        logic [PIX_W-1:0]  ad;
        for (int s = 0; s < WINDOW; s++) begin
            b  = slot_wrap((SLOT_W+1)'(tag.kb) + (SLOT_W+1)'(WINDOW) - (SLOT_W+1)'(s));
            rv = rpatch_reg[tag.a][b];
            ad = (rv > left_pix) ? rv - left_pix : left_pix - rv;
            acc_sum[s] = acc_reg[s] + COST_W'(ad);
        end
    end

    assign fin_slot  = slot_wrap((SLOT_W+1)'(tag.kb) + (SLOT_W+1)'(1));
    assign fin_hit   = tag.valid && tag.is_left && (tag.a == SLOT_W'(WINDOW - 1));
    assign disp_wide = K_W'(disp_min) + tag.k - K_W'(WINDOW - 1);

    always_ff @(posedge aclk) begin
        if (tag.valid && !tag.is_left) begin
            rpatch_reg[tag.a][tag.b] <= right_pix;
        end
        if (init) begin
            for (int s = 0; s < WINDOW; s++) begin
                acc_reg[s] <= '0;
            end
        end else if (tag.valid && tag.is_left) begin
            for (int s = 0; s < WINDOW; s++) begin
                if (fin_hit && (fin_slot == SLOT_W'(s))) begin
                    acc_reg[s] <= '0;
                end else begin
                    acc_reg[s] <= acc_sum[s];
                end
            end
        end
        fin_cost_reg <= acc_sum[fin_slot];
        fin_disp_reg <= disp_wide[DISP_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
            best_cost_reg <= COST_LIMIT;
            best_disp_reg <= '0;
        end else begin
            fin_valid_reg <= fin_hit && (tag.k >= K_W'(WINDOW - 1));
            if (init) begin
                best_cost_reg <= COST_LIMIT;
                best_disp_reg <= disp_min;
            end else if (fin_valid_reg && (fin_cost_reg < best_cost_reg)) begin
                best_cost_reg <= fin_cost_reg;
                best_disp_reg <= fin_disp_reg;
            end
        end
    end

    assign best_disp = best_disp_reg;

endmodule

// File: dv/tb_sad_stereo_block_match_unit.sv
// Self-checking testbench for the SAD stereo block matcher: whole frames, shadow model, stalls.
`timescale 1ns / 1ps

module tb_sad_stereo_block_match_unit;
    import ssbm_pkg::*;

    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [DISP_W-1:0] disp;
        logic              last;
    } match_t;

    localparam int QUIET_PAUSE = 1500;
    localparam int STALL_LIMIT = 20000;

    localparam int PAT_RANDOM  = 0;
    localparam int PAT_ZERO    = 1;
    localparam int PAT_SPLIT   = 2;
    localparam int PAT_SHIFTED = 3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [15:0] pixel_queue[$];
    match_t      match_queue[$];

    logic [PIX_W-1:0] left_rows  [DEPTH];
    logic [PIX_W-1:0] right_rows [DEPTH];
    int unsigned cur_row, cur_col;
    int unsigned reg_width = 640, reg_height = 480, reg_dmin = 0, reg_dmax = 64;

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_count = 0;

    sad_stereo_block_match_unit dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned frame_width();
        return (reg_width < 1) ? 1 : (reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width;
    endfunction

    function automatic int unsigned frame_height();
        return (reg_height < 1) ? 1 : (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height;
    endfunction

    function automatic int unsigned row_addr(int unsigned row, int unsigned col);
        return (row % WINDOW) * MAX_WIDTH + (col % MAX_WIDTH);
    endfunction

    function automatic void predict_match(logic [15:0] pix);
        int unsigned w, h, r, c, i, j, best_sum, best_d, sum, rr, cr, rv, lv;
        match_t m;
        w = frame_width();
        h = frame_height();
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= h) cur_row = 0;
        r = cur_row;
        c = cur_col;
        left_rows[row_addr(r, c)]  = pix[7:0];
        right_rows[row_addr(r, c)] = pix[15:8];
        if (r >= 2 * WIN && c >= 2 * WIN + reg_dmax) begin
            i = r - WIN;
            j = c - WIN - reg_dmax;
            best_sum = COST_LIMIT;
            best_d = reg_dmin;
            for (int unsigned d = reg_dmin; d <= reg_dmax; d++) begin
                sum = 0;
                for (int a = 0; a < WINDOW; a++) begin
                    rr = i + a - WIN;
                    for (int b = 0; b < WINDOW; b++) begin
                        cr = j + b - WIN;
                        rv = right_rows[row_addr(rr, cr)];
                        lv = left_rows[row_addr(rr, cr + d)];
                        sum += (rv > lv) ? rv - lv : lv - rv;
                    end
                end
                if (sum < best_sum) begin
                    best_sum = sum;
                    best_d = d;
                end
            end
            m.row  = i[ROW_W-1:0];
            m.col  = j[COL_W-1:0];
            m.disp = best_d[DISP_W-1:0];
            m.last = (r == h - 1 && c == w - 1);
            match_queue.push_back(m);
        end
        cur_col = c + 1;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row = r + 1;
            if (cur_row >= h) cur_row = 0;
        end
    endfunction

    function automatic bit take_break();
        return (cycle_count % 16384) >= 4096 && $urandom_range(0, 99) < 6;
    endfunction

    // driver: predict on each accepted transfer, then present the next pixel pair
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_match(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pixel_queue.size() > 0 && !take_break()) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        match_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !take_break();
            if (m_tvalid && m_tready) begin
                if (match_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result row=%0d col=%0d disp=%0d last=%0b",
                                 m_tdata[11:0], m_tdata[21:12], m_tdata[29:22], m_tlast);
                end else begin
                    e = match_queue.pop_front();
                    if (m_tdata[11:0] !== e.row || m_tdata[21:12] !== e.col ||
                        m_tdata[29:22] !== e.disp || m_tlast !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp row=%0d col=%0d disp=%0d last=%0b",
                                     e.row, e.col, e.disp, e.last);
                            $display("         got row=%0d col=%0d disp=%0d last=%0b",
                                     m_tdata[11:0], m_tdata[21:12], m_tdata[29:22],
                                     m_tlast);
                        end
                    end
                end
            end
        end
    end

    // watchdog: count cycles with work pending and no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pixel_queue.size() == 0 && match_queue.size() == 0 && !s_tvalid)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic write_reg(cfg_idx_t idx, int unsigned value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_WIDTH:    reg_width  = value & 11'h7FF;
            CFG_HEIGHT:   reg_height = value & 13'h1FFF;
            CFG_DISP_MIN: reg_dmin   = value & 8'hFF;
            CFG_DISP_MAX: reg_dmax   = value & 8'hFF;
            default: ;
        endcase
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned dmin,
                                int unsigned dmax);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_DISP_MIN, dmin);
        write_reg(CFG_DISP_MAX, dmax);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_frame(int pattern, output int unsigned count);
        int unsigned w, h, shift;
        logic [7:0] l, r;
        w = frame_width();
        h = frame_height();
        shift = $urandom_range(0, 7);
        count = w * h;
        for (int unsigned y = 0; y < h; y++) begin
            for (int unsigned x = 0; x < w; x++) begin
                case (pattern)
                    PAT_ZERO:  begin l = 8'h00; r = 8'h00; end
                    PAT_SPLIT: begin l = 8'hFF; r = 8'h00; end
                    PAT_SHIFTED: begin
                        r = 8'((x * 37 + y * 91) ^ (x * x));
                        l = 8'(((x - shift) * 37 + y * 91) ^ ((x - shift) * (x - shift)));
                    end
                    default: begin l = 8'($urandom); r = 8'($urandom); end
                endcase
                pixel_queue.push_back({r, l});
            end
        end
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pixel_queue.size() > 0 || s_tvalid || match_queue.size() > 0);
        repeat (QUIET_PAUSE) @(posedge aclk);
    endtask

    task automatic run_frame(int unsigned w, int unsigned h, int unsigned dmin,
                             int unsigned dmax, int pattern, output int unsigned count);
        set_geometry(w, h, dmin, dmax);
        queue_frame(pattern, count);
        drain();
    endtask

    initial begin
        int unsigned sent, n, dmax, dmin;
        cur_row = 0;
        cur_col = 0;
        sent = 0;
        for (int k = 0; k < DEPTH; k++) begin
            left_rows[k] = '0;
            right_rows[k] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        run_frame(8, 6, 0, 1, PAT_ZERO, n);
        sent += n;
        run_frame(9, 6, 0, 1, PAT_SPLIT, n);
        sent += n;
        run_frame(10, 5, 3, 2, PAT_RANDOM, n);
        sent += n;
        run_frame(16, 6, 0, 7, PAT_SHIFTED, n);
        sent += n;
        run_frame(2047, 1, 250, 255, PAT_RANDOM, n);
        sent += n;
        run_frame(0, 0, 254, 255, PAT_RANDOM, n);
        sent += n;
        run_frame(3, 3, 0, 64, PAT_RANDOM, n);
        sent += n;

        while (sent < 1650) begin
            dmax = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            dmin = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, dmax);
            set_geometry($urandom_range(dmax + 5, dmax + 20), $urandom_range(5, 8), dmin, dmax);
            queue_frame(($urandom_range(0, 3) == 0) ? PAT_SHIFTED : PAT_RANDOM, n);
            sent += n;
            drain();
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
